FILE: sv/lcb_pkg.sv
// ----------------------------------------------------------------------------
// lcb_pkg
// Shared opcodes, status codes and interface structs of the canvas blitter.
// ----------------------------------------------------------------------------
package lcb_pkg;

  // command codes
  localparam logic [3:0] OP_DEFINE = 4'd0;
  localparam logic [3:0] OP_MAPLN  = 4'd1;
  localparam logic [3:0] OP_SET    = 4'd2;
  localparam logic [3:0] OP_GET    = 4'd3;
  localparam logic [3:0] OP_FILL   = 4'd4;
  localparam logic [3:0] OP_COPY   = 4'd5;
  localparam logic [3:0] OP_KEYED  = 4'd6;
  localparam logic [3:0] OP_BSTART = 4'd7;
  localparam logic [3:0] OP_BDATA  = 4'd8;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OFS_LARGE = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_CANVAS_BIG = 3'd3;
  localparam logic [2:0] ST_NO_BLIT   = 3'd4;

  localparam logic [15:0] UNMAPPED     = 16'hFFFF;
  localparam logic [15:0] OFFSET_LIMIT = 16'd32767;

  // one request to a single-port memory
  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

  // operands of the shared multiply-add unit: a * b + c
  typedef struct packed {
    logic        [12:0] a;
    logic signed [13:0] b;
    logic        [11:0] c;
  } mac_in_t;

endpackage

FILE: sv/lcb_mac.sv
// ----------------------------------------------------------------------------
// lcb_mac
// Shared registered multiply-add unit: cell addresses, area and line ends.
// ----------------------------------------------------------------------------
module lcb_mac (
  input  logic                clk,
  input  lcb_pkg::mac_in_t    mac_in,
  output logic signed [28:0]  mac_q
);
  import lcb_pkg::*;

  logic signed [28:0] sum;

  // form a * b + c with a and c unsigned
  assign sum = 29'($signed({1'b0, mac_in.a}) * mac_in.b) + 29'($signed({1'b0, mac_in.c}));

  always_ff @(posedge clk) begin
    mac_q <= sum;
  end

endmodule

FILE: sv/lcb_mem.sv
// ----------------------------------------------------------------------------
// lcb_mem
// Pixel map, LED color store and scratch buffer, single port, registered read.
// ----------------------------------------------------------------------------
module lcb_mem #(
  parameter int MAP_CELLS = 4096,
  parameter int LED_DEPTH = 2048
) (
  input  logic               clk,
  input  lcb_pkg::mem_req_t  map_req,
  input  lcb_pkg::mem_req_t  led_req,
  input  lcb_pkg::mem_req_t  scr_req,
  output logic [15:0]        map_q,
  output logic [31:0]        led_q,
  output logic [31:0]        scr_q
);
  import lcb_pkg::*;

  localparam int MAP_AW = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int LED_AW = (LED_DEPTH > 1) ? $clog2(LED_DEPTH) : 1;

  logic [15:0] map_mem [MAP_CELLS];
  logic [31:0] led_mem [LED_DEPTH];
  logic [31:0] scr_mem [MAP_CELLS];

  // pixel map port
  always_ff @(posedge clk) begin
    if (map_req.we) begin
      map_mem[map_req.addr[MAP_AW-1:0]] <= map_req.wdata[15:0];
    end else if (map_req.re) begin
      map_q <= map_mem[map_req.addr[MAP_AW-1:0]];
    end
  end

  // LED store port
  always_ff @(posedge clk) begin
    if (led_req.we) begin
      led_mem[led_req.addr[LED_AW-1:0]] <= led_req.wdata;
    end else if (led_req.re) begin
      led_q <= led_mem[led_req.addr[LED_AW-1:0]];
    end
  end

  // scratch buffer port
  always_ff @(posedge clk) begin
    if (scr_req.we) begin
      scr_mem[scr_req.addr[MAP_AW-1:0]] <= scr_req.wdata;
    end else if (scr_req.re) begin
      scr_q <= scr_mem[scr_req.addr[MAP_AW-1:0]];
    end
  end

endmodule

FILE: sv/led_canvas_blitter_core.sv
// ----------------------------------------------------------------------------
// led_canvas_blitter_core
// 2D drawing engine over an LED canvas mapped cell by cell to two strips.
// ----------------------------------------------------------------------------
// One command is taken at a time and gives one result beat. After reset the
// map and LED store are swept clear over max(MAP_CELLS, 2*LEDS_PER_STRIP)
// addresses, during which in_stall is high. Each cell access goes through the
// shared multiply-add unit for the cell address, then the map read and the LED
// store access; a map line writes the map instead and skips the LED store.
// Copy reads every source cell into scratch before it writes the destination,
// and an accepted canvas definition clears the whole map. Blit start, blit
// data that writes nothing, unknown ops and commands rejected at decode go
// from decode straight to the response. A stalled result beat holds the
// engine in its response state until it is taken.
module led_canvas_blitter_core #(
  parameter int MAP_CELLS      = 4096,
  parameter int LEDS_PER_STRIP = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_op,
  input  logic [11:0] in_x_pos,
  input  logic [11:0] in_y_pos,
  input  logic [11:0] in_dest_x,
  input  logic [11:0] in_dest_y,
  input  logic [12:0] in_span_w,
  input  logic [12:0] in_span_h,
  input  logic        in_strip_sel,
  input  logic [14:0] in_led_offset,
  input  logic signed [7:0] in_step_x,
  input  logic signed [7:0] in_step_y,
  input  logic [31:0] in_pixel_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_color
);
  import lcb_pkg::*;

  localparam int MAP_AW    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int LED_DEPTH = 2 * LEDS_PER_STRIP;
  localparam int CLR_N     = (MAP_CELLS > LED_DEPTH) ? MAP_CELLS : LED_DEPTH;
  localparam int CLR_W     = $clog2(CLR_N + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_DEF   = 4'd3;
  localparam logic [3:0] S_DCLR  = 4'd4;
  localparam logic [3:0] S_LX    = 4'd5;
  localparam logic [3:0] S_LY    = 4'd6;
  localparam logic [3:0] S_CELL  = 4'd7;
  localparam logic [3:0] S_MAPRD = 4'd8;
  localparam logic [3:0] S_LEDA  = 4'd9;
  localparam logic [3:0] S_LEDD  = 4'd10;
  localparam logic [3:0] S_STEP  = 4'd11;
  localparam logic [3:0] S_RESP  = 4'd12;

  logic [3:0]  state_r;
  logic [3:0]  op_r;
  logic [11:0] x_r, y_r, dx_r, dy_r;
  logic [12:0] w_r, h_r;
  logic        strip_r;
  logic [14:0] ent_r;
  logic [7:0]  sx_r, sy_r;
  logic [31:0] color_r;
  logic [12:0] cw_r, ch_r;
  logic        blit_act_r;
  logic [11:0] bo_x_r, bo_y_r, bc_col_r, bc_row_r;
  logic [12:0] bs_w_r, bs_h_r;
  logic [11:0] cur_x_r, cur_y_r, base_x_r;
  logic [12:0] col_r, row_r;
  logic [MAP_AW-1:0] k_r;
  logic        phase_r, lx_ok_r, cell_ok_r, ledok_r;
  logic [CLR_W-1:0] clr_r;
  logic [2:0]  status_r;
  logic [31:0] rc_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_color_r;

  mac_in_t            mac_in;
  logic signed [28:0] mac_q;
  logic [28:0]        mac_u;
  mem_req_t           map_req, led_req, scr_req;
  logic [15:0]        map_q;
  logic [31:0]        led_q, scr_q;

  logic        cell_ok, map_ok, rd_mode, copying, skip;
  logic [31:0] wval, rval;
  logic [16:0] led_idx;
  logic        src_bad, dst_bad, rect_zero, ofs_bad, mac_in_cw;
  logic [12:0] bx_sum, by_sum, col_inc, row_inc;
  logic [11:0] sx_ext, sy_ext;

  lcb_mac u_mac (
    .clk    (clk),
    .mac_in (mac_in),
    .mac_q  (mac_q)
  );

  lcb_mem #(
    .MAP_CELLS (MAP_CELLS),
    .LED_DEPTH (LED_DEPTH)
  ) u_mem (
    .clk     (clk),
    .map_req (map_req),
    .led_req (led_req),
    .scr_req (scr_req),
    .map_q   (map_q),
    .led_q   (led_q),
    .scr_q   (scr_q)
  );

  // command checks and derived values
  assign mac_u     = mac_q;
  assign cell_ok   = mac_u < 29'(MAP_CELLS);
  assign mac_in_cw = !mac_q[28] && (mac_u < 29'(cw_r));
  assign map_ok    = cell_ok_r && (map_q != UNMAPPED) && (32'(map_q[14:0]) < 32'(LEDS_PER_STRIP));
  assign led_idx   = map_q[15] ? 17'(LEDS_PER_STRIP) + 17'(map_q[14:0]) : 17'(map_q[14:0]);
  assign copying   = (op_r == OP_COPY) || (op_r == OP_KEYED);
  assign rd_mode   = (op_r == OP_GET) || (copying && !phase_r);
  assign wval      = (copying && phase_r) ? scr_q : color_r;
  assign skip      = (op_r == OP_KEYED) && (wval == 32'd0);
  assign rval      = ledok_r ? led_q : 32'd0;
  assign src_bad   = (14'(x_r) + 14'(w_r) > 14'(cw_r)) || (14'(y_r) + 14'(h_r) > 14'(ch_r));
  assign dst_bad   = (14'(dx_r) + 14'(w_r) > 14'(cw_r)) || (14'(dy_r) + 14'(h_r) > 14'(ch_r));
  assign rect_zero = (w_r == 13'd0) || (h_r == 13'd0);
  assign ofs_bad   = (w_r != 13'd0) && (16'(ent_r) + 16'(w_r) - 16'd1 >= OFFSET_LIMIT);
  assign bx_sum    = 13'(bo_x_r) + 13'(bc_col_r);
  assign by_sum    = 13'(bo_y_r) + 13'(bc_row_r);
  assign col_inc   = col_r + 13'd1;
  assign row_inc   = row_r + 13'd1;
  assign sx_ext    = {{4{sx_r[7]}}, sx_r};
  assign sy_ext    = {{4{sy_r[7]}}, sy_r};

  // select operands of the shared unit
  always_comb begin
    mac_in.a = cw_r;
    mac_in.b = $signed({2'b00, cur_y_r});
    mac_in.c = cur_x_r;
    case (state_r)
      S_DEC: begin
        if (op_r == OP_DEFINE) begin
          mac_in.a = w_r;
          mac_in.b = $signed({1'b0, h_r});
          mac_in.c = 12'd0;
        end else begin
          mac_in.a = w_r - 13'd1;
          mac_in.b = $signed({{6{sx_r[7]}}, sx_r});
          mac_in.c = x_r;
        end
      end
      S_LX: begin
        mac_in.a = w_r - 13'd1;
        mac_in.b = $signed({{6{sy_r[7]}}, sy_r});
        mac_in.c = y_r;
      end
      default: begin
        mac_in.a = cw_r;
      end
    endcase
  end

  // drive memory requests
  always_comb begin
    map_req = '0;
    led_req = '0;
    scr_req = '0;
    case (state_r)
      S_CLR: begin
        map_req.we    = 32'(clr_r) < 32'(MAP_CELLS);
        map_req.addr  = 16'(clr_r);
        map_req.wdata = 32'(UNMAPPED);
        led_req.we    = 32'(clr_r) < 32'(LED_DEPTH);
        led_req.addr  = 16'(clr_r);
      end
      S_DCLR: begin
        map_req.we    = 1'b1;
        map_req.addr  = 16'(clr_r);
        map_req.wdata = 32'(UNMAPPED);
      end
      S_CELL: begin
        scr_req.re   = copying && phase_r;
        scr_req.addr = 16'(k_r);
      end
      S_MAPRD: begin
        map_req.addr  = mac_u[15:0];
        map_req.wdata = 32'({strip_r, ent_r});
        map_req.we    = (op_r == OP_MAPLN) && cell_ok;
        map_req.re    = (op_r != OP_MAPLN);
      end
      S_LEDA: begin
        led_req.addr  = led_idx[15:0];
        led_req.wdata = wval;
        led_req.re    = map_ok && rd_mode;
        led_req.we    = map_ok && !rd_mode && !skip;
      end
      S_LEDD: begin
        scr_req.we    = copying && !phase_r;
        scr_req.addr  = 16'(k_r);
        scr_req.wdata = rval;
      end
      default: begin
        scr_req = '0;
      end
    endcase
  end

  // sequence one command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      cw_r        <= '0;
      ch_r        <= '0;
      blit_act_r  <= 1'b0;
      bo_x_r      <= '0;
      bo_y_r      <= '0;
      bs_w_r      <= '0;
      bs_h_r      <= '0;
      bc_col_r    <= '0;
      bc_row_r    <= '0;
    end else begin
      // drop a taken result beat unless a new one is loaded
      if (out_valid_r && !out_stall && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == CLR_N - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            x_r      <= in_x_pos;
            y_r      <= in_y_pos;
            dx_r     <= in_dest_x;
            dy_r     <= in_dest_y;
            w_r      <= in_span_w;
            h_r      <= in_span_h;
            strip_r  <= in_strip_sel;
            ent_r    <= in_led_offset;
            sx_r     <= in_step_x;
            sy_r     <= in_step_y;
            color_r  <= in_pixel_color;
            status_r <= ST_OK;
            rc_r     <= 32'd0;
            state_r  <= S_DEC;
          end
        end
        S_DEC: begin
          case (op_r)
            OP_DEFINE: state_r <= S_DEF;
            OP_MAPLN: begin
              if (ofs_bad) begin
                status_r <= ST_OFS_LARGE;
                state_r  <= S_RESP;
              end else if (w_r != 13'd0) begin
                state_r <= S_LX;
              end else begin
                state_r <= S_RESP;
              end
            end
            OP_SET, OP_GET: begin
              if (13'(x_r) >= cw_r || 13'(y_r) >= ch_r) begin
                status_r <= ST_OUTSIDE;
                state_r  <= S_RESP;
              end else begin
                cur_x_r <= x_r;
                cur_y_r <= y_r;
                state_r <= S_CELL;
              end
            end
            OP_FILL, OP_COPY, OP_KEYED: begin
              if (src_bad || (copying && dst_bad)) begin
                status_r <= ST_OUTSIDE;
                state_r  <= S_RESP;
              end else if (!rect_zero) begin
                cur_x_r  <= x_r;
                cur_y_r  <= y_r;
                base_x_r <= x_r;
                col_r    <= '0;
                row_r    <= '0;
                k_r      <= '0;
                phase_r  <= 1'b0;
                state_r  <= S_CELL;
              end else begin
                state_r <= S_RESP;
              end
            end
            OP_BSTART: begin
              state_r <= S_RESP;
              if (src_bad) begin
                blit_act_r <= 1'b0;
                status_r   <= ST_OUTSIDE;
              end else begin
                bo_x_r     <= x_r;
                bo_y_r     <= y_r;
                bs_w_r     <= w_r;
                bs_h_r     <= h_r;
                bc_col_r   <= '0;
                bc_row_r   <= '0;
                blit_act_r <= !rect_zero;
              end
            end
            OP_BDATA: begin
              if (!blit_act_r) begin
                status_r <= ST_NO_BLIT;
                state_r  <= S_RESP;
              end else begin
                cur_x_r <= bx_sum[11:0];
                cur_y_r <= by_sum[11:0];
                // advance cursor in row-major order
                if (13'(bc_col_r) + 13'd1 >= bs_w_r) begin
                  bc_col_r <= '0;
                  if (13'(bc_row_r) + 13'd1 >= bs_h_r) begin
                    blit_act_r <= 1'b0;
                    bc_row_r   <= '0;
                  end else begin
                    bc_row_r <= bc_row_r + 12'd1;
                  end
                end else begin
                  bc_col_r <= bc_col_r + 12'd1;
                end
                if (color_r != 32'd0 && bx_sum < cw_r && by_sum < ch_r) begin
                  state_r <= S_CELL;
                end else begin
                  state_r <= S_RESP;
                end
              end
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_DEF: begin
          if (mac_u > 29'(MAP_CELLS)) begin
            status_r <= ST_CANVAS_BIG;
            state_r  <= S_RESP;
          end else begin
            cw_r       <= w_r;
            ch_r       <= h_r;
            blit_act_r <= 1'b0;
            clr_r      <= '0;
            state_r    <= S_DCLR;
          end
        end
        S_DCLR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAP_CELLS - 1) begin
            state_r <= S_RESP;
          end
        end
        S_LX: begin
          lx_ok_r <= mac_in_cw;
          state_r <= S_LY;
        end
        S_LY: begin
          if (13'(x_r) >= cw_r || 13'(y_r) >= ch_r || !lx_ok_r || mac_q[28] ||
              mac_u >= 29'(ch_r)) begin
            status_r <= ST_OUTSIDE;
            state_r  <= S_RESP;
          end else begin
            cur_x_r <= x_r;
            cur_y_r <= y_r;
            col_r   <= '0;
            state_r <= S_CELL;
          end
        end
        S_CELL: state_r <= S_MAPRD;
        S_MAPRD: begin
          cell_ok_r <= cell_ok;
          state_r   <= (op_r == OP_MAPLN) ? S_STEP : S_LEDA;
        end
        S_LEDA: begin
          ledok_r <= map_ok;
          state_r <= rd_mode ? S_LEDD : S_STEP;
        end
        S_LEDD: begin
          if (op_r == OP_GET) begin
            rc_r <= rval;
          end
          state_r <= S_STEP;
        end
        S_STEP: begin
          case (op_r)
            OP_MAPLN: begin
              if (col_inc < w_r) begin
                col_r   <= col_inc;
                cur_x_r <= cur_x_r + sx_ext;
                cur_y_r <= cur_y_r + sy_ext;
                ent_r   <= ent_r + 15'd1;
                state_r <= S_CELL;
              end else begin
                state_r <= S_RESP;
              end
            end
            OP_FILL, OP_COPY, OP_KEYED: begin
              if (col_inc < w_r) begin
                k_r     <= k_r + 1'b1;
                col_r   <= col_inc;
                cur_x_r <= cur_x_r + 12'd1;
                state_r <= S_CELL;
              end else if (row_inc < h_r) begin
                k_r     <= k_r + 1'b1;
                col_r   <= '0;
                row_r   <= row_inc;
                cur_x_r <= base_x_r;
                cur_y_r <= cur_y_r + 12'd1;
                state_r <= S_CELL;
              end else if (copying && !phase_r) begin
                // source held in scratch: start writing the destination
                phase_r  <= 1'b1;
                k_r      <= '0;
                col_r    <= '0;
                row_r    <= '0;
                cur_x_r  <= dx_r;
                cur_y_r  <= dy_r;
                base_x_r <= dx_r;
                state_r  <= S_CELL;
              end else begin
                state_r <= S_RESP;
              end
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_color_r  <= (status_r == ST_OK) ? rc_r : 32'd0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_color = out_color_r;

endmodule

FILE: sv/lcb_checker.sv
// ----------------------------------------------------------------------------
// lcb_checker
// Port-level checks of the canvas blitter, bound to the top level.
// ----------------------------------------------------------------------------
module lcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_read_color
);
  import lcb_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_read_color))
    else $error("stalled result beat changed");

  // one command in flight: stall right after a command beat
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command taken while busy");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NO_BLIT)
    else $error("bad status code");

  // a read color only comes with an ok status
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_color != 32'd0 |-> out_status == ST_OK)
    else $error("color with error status");

endmodule

bind led_canvas_blitter_core lcb_checker u_lcb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_color (out_read_color)
);

FILE: test/led_canvas_blitter_core_tb.sv
// ----------------------------------------------------------------------------
// led_canvas_blitter_core_tb
// Self-checking bench for the canvas blitter core. A queue of commands drives
// the input channel and each accepted beat updates a local copy of the
// canvas, map and LED store to predict its result. The monitor compares every
// result beat with the oldest prediction while both sides idle and stall in
// several phases.
// ----------------------------------------------------------------------------
module led_canvas_blitter_core_tb;
  import lcb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CELLS  = 4096;
  localparam int STRIP_LEDS = 1024;
  localparam int N_RANDOM   = 430;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct {
    logic [3:0]        op;
    logic [11:0]       x, y, dx, dy;
    logic [12:0]       w, h;
    logic              strip;
    logic [14:0]       loff;
    logic signed [7:0] sx, sy;
    logic [31:0]       color;
  } cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] color;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic [11:0] in_x_pos = '0, in_y_pos = '0, in_dest_x = '0, in_dest_y = '0;
  logic [12:0] in_span_w = '0, in_span_h = '0;
  logic in_strip_sel = 1'b0;
  logic [14:0] in_led_offset = '0;
  logic signed [7:0] in_step_x = '0, in_step_y = '0;
  logic [31:0] in_pixel_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_read_color;

  led_canvas_blitter_core u_dut (.*);

  always #1 clk = ~clk;

  // predicted device state
  logic [15:0] cell_map [NUM_CELLS];
  logic [31:0] led_mem [2*STRIP_LEDS];
  logic [31:0] copy_buf [NUM_CELLS];
  int canvas_w, canvas_h;
  logic blit_on;
  int blit_ox, blit_oy, blit_w, blit_h, blit_col, blit_row;

  cmd_t    cmd_q[$];
  result_t result_q[$];
  cmd_t    cur_cmd;
  int      n_total, n_sent, n_results, n_errors, n_cycles, phase;
  int      gen_w, gen_h;

  function automatic int led_slot(int x, int y);
    int cell_idx;
    int off;
    cell_idx = canvas_w * y + x;
    if (cell_idx < 0 || cell_idx >= NUM_CELLS) return -1;
    if (cell_map[cell_idx] == UNMAPPED) return -1;
    off = cell_map[cell_idx][14:0];
    if (off >= STRIP_LEDS) return -1;
    return cell_map[cell_idx][15] * STRIP_LEDS + off;
  endfunction

  function automatic logic [31:0] read_led(int x, int y);
    int i;
    i = led_slot(x, y);
    return (i < 0) ? 32'h0 : led_mem[i];
  endfunction

  function automatic void write_led(int x, int y, logic [31:0] c);
    int i;
    i = led_slot(x, y);
    if (i >= 0) led_mem[i] = c;
  endfunction

  // apply one command to the predicted state and return its result
  function automatic result_t blit_predict(cmd_t c);
    result_t res;
    int x, y, dx, dy, w, h, sx, sy, lx, ly;
    res = '{ST_OK, 32'h0};
    x = c.x; y = c.y; dx = c.dx; dy = c.dy; w = c.w; h = c.h;
    sx = c.sx; sy = c.sy;
    case (c.op)
      OP_DEFINE: begin
        if (w * h > NUM_CELLS) begin
          res.status = ST_CANVAS_BIG;
        end else begin
          canvas_w = w; canvas_h = h;
          foreach (cell_map[i]) cell_map[i] = UNMAPPED;
          blit_on = 1'b0;
        end
      end
      OP_MAPLN: begin
        lx = x + (w - 1) * sx;
        ly = y + (w - 1) * sy;
        if (w != 0 && int'(c.loff) + w - 1 >= int'(OFFSET_LIMIT)) begin
          res.status = ST_OFS_LARGE;
        end else if (w != 0) begin
          if (x >= canvas_w || lx < 0 || lx >= canvas_w ||
              y >= canvas_h || ly < 0 || ly >= canvas_h) begin
            res.status = ST_OUTSIDE;
          end else begin
            for (int i = 0; i < w; i++) begin
              lx = canvas_w * (y + i * sy) + x + i * sx;
              if (lx < NUM_CELLS) cell_map[lx] = {c.strip, 15'(int'(c.loff) + i)};
            end
          end
        end
      end
      OP_SET, OP_GET: begin
        if (x >= canvas_w || y >= canvas_h) res.status = ST_OUTSIDE;
        else if (c.op == OP_SET) write_led(x, y, c.color);
        else res.color = read_led(x, y);
      end
      OP_FILL: begin
        if (x + w > canvas_w || y + h > canvas_h) res.status = ST_OUTSIDE;
        else
          for (int r = 0; r < h; r++)
            for (int k = 0; k < w; k++) write_led(x + k, y + r, c.color);
      end
      OP_COPY, OP_KEYED: begin
        if (x + w > canvas_w || y + h > canvas_h ||
            dx + w > canvas_w || dy + h > canvas_h) begin
          res.status = ST_OUTSIDE;
        end else begin
          // read the whole source first so overlaps copy at once
          for (int r = 0; r < h; r++)
            for (int k = 0; k < w; k++)
              if (r * w + k < NUM_CELLS) copy_buf[r*w+k] = read_led(x + k, y + r);
          for (int r = 0; r < h; r++)
            for (int k = 0; k < w; k++)
              if (copy_buf[r*w+k] != 0 || c.op == OP_COPY)
                write_led(dx + k, dy + r, copy_buf[r*w+k]);
        end
      end
      OP_BSTART: begin
        blit_on = 1'b0;
        if (x + w > canvas_w || y + h > canvas_h) begin
          res.status = ST_OUTSIDE;
        end else begin
          blit_ox = x; blit_oy = y; blit_w = w; blit_h = h;
          blit_col = 0; blit_row = 0;
          blit_on = (w != 0 && h != 0);
        end
      end
      OP_BDATA: begin
        if (!blit_on) begin
          res.status = ST_NO_BLIT;
        end else begin
          if (c.color != 0 && blit_ox + blit_col < canvas_w &&
              blit_oy + blit_row < canvas_h)
            write_led(blit_ox + blit_col, blit_oy + blit_row, c.color);
          blit_col++;
          if (blit_col >= blit_w) begin blit_col = 0; blit_row++; end
          if (blit_row >= blit_h) begin blit_on = 1'b0; blit_row = 0; blit_col = 0; end
          blit_col &= 'hFFF; blit_row &= 'hFFF;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // random well-formed command on the current canvas, or noise
  function automatic cmd_t gen_cmd();
    cmd_t c;
    int pick, n, sx, sy;
    c.op = 4'($urandom_range(0, 15));
    c.x = 12'($urandom); c.y = 12'($urandom);
    c.dx = 12'($urandom); c.dy = 12'($urandom);
    c.w = 13'($urandom); c.h = 13'($urandom);
    c.strip = 1'($urandom); c.loff = 15'($urandom);
    c.sx = 8'($urandom); c.sy = 8'($urandom);
    c.color = $urandom;
    pick = $urandom_range(0, 99);
    if (gen_w == 0 || pick < 3) begin
      c.op = OP_DEFINE;
      c.w = 13'($urandom_range(1, 16)); c.h = 13'($urandom_range(1, 16));
    end else if (pick < 90) begin
      c.x = 12'($urandom_range(0, gen_w - 1)); c.y = 12'($urandom_range(0, gen_h - 1));
      c.dx = 12'($urandom_range(0, gen_w - 1)); c.dy = 12'($urandom_range(0, gen_h - 1));
      c.w = 13'($urandom_range(1, gen_w - ((c.x > c.dx) ? c.x : c.dx)));
      c.h = 13'($urandom_range(1, gen_h - ((c.y > c.dy) ? c.y : c.dy)));
      if ($urandom_range(0, 3) == 0) c.color = 32'h0;
      if (pick < 18) begin
        c.op = OP_MAPLN;
        c.loff = 15'($urandom_range(0, 1100));
        sx = $urandom_range(0, 2) - 1; sy = $urandom_range(0, 2) - 1;
        n = $urandom_range(1, 8);
        while (n > 1 && (int'(c.x) + (n-1)*sx < 0 || int'(c.x) + (n-1)*sx >= gen_w ||
                         int'(c.y) + (n-1)*sy < 0 || int'(c.y) + (n-1)*sy >= gen_h)) n--;
        c.w = 13'(n); c.sx = 8'(sx); c.sy = 8'(sy);
      end
      else if (pick < 33) c.op = OP_SET;
      else if (pick < 48) c.op = OP_GET;
      else if (pick < 56) c.op = OP_FILL;
      else if (pick < 63) c.op = OP_COPY;
      else if (pick < 70) c.op = OP_KEYED;
      else if (pick < 75) c.op = OP_BSTART;
      else c.op = OP_BDATA;
    end
    if (c.op == OP_DEFINE && int'(c.w) * int'(c.h) <= NUM_CELLS) begin
      gen_w = c.w; gen_h = c.h;
    end
    return c;
  endfunction

  function automatic cmd_t mk(logic [3:0] op, int x, int y, int dx, int dy, int w, int h,
                              int loff, int sx, int sy, logic [31:0] color);
    cmd_t c;
    c = '{op, 12'(x), 12'(y), 12'(dx), 12'(dy), 13'(w), 13'(h), 1'b0, 15'(loff),
          8'(sx), 8'(sy), color};
    if (op == OP_DEFINE && w * h <= NUM_CELLS) begin gen_w = w; gen_h = h; end
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH beat %0d %s: got %h expected %h", n_results, what, got, want);
    n_errors++;
  endtask

  // pick idle and stall rates by phase
  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // drive commands; predict on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(blit_predict(cur_cmd));
        n_sent++;
        phase = n_sent * 4 / n_total;
      end
      if (!(in_valid && in_stall)) begin
        if (cmd_q.size() > 0 &&
            !roll(phase == 1 ? 88 : (phase == 3 ? 22 : 0))) begin
          cur_cmd = cmd_q.pop_front();
          in_op <= cur_cmd.op;
          in_x_pos <= cur_cmd.x;        in_y_pos <= cur_cmd.y;
          in_dest_x <= cur_cmd.dx;      in_dest_y <= cur_cmd.dy;
          in_span_w <= cur_cmd.w;       in_span_h <= cur_cmd.h;
          in_strip_sel <= cur_cmd.strip; in_led_offset <= cur_cmd.loff;
          in_step_x <= cur_cmd.sx;      in_step_y <= cur_cmd.sy;
          in_pixel_color <= cur_cmd.color;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // check result beats and apply back-pressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected beat", {29'h0, out_status}, 32'h0);
        end else begin
          if (out_status !== result_q[0].status)
            report_mismatch("status", {29'h0, out_status}, {29'h0, result_q[0].status});
          if (out_read_color !== result_q[0].color)
            report_mismatch("read_color", out_read_color, result_q[0].color);
          void'(result_q.pop_front());
        end
        n_results++;
      end
      out_stall <= roll(phase == 2 ? 88 : (phase == 3 ? 22 : 0));
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("timeout with %0d results outstanding", result_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    foreach (cell_map[i]) cell_map[i] = UNMAPPED;
    foreach (led_mem[i]) led_mem[i] = 32'h0;
    canvas_w = 0; canvas_h = 0; blit_on = 1'b0;
    gen_w = 0; gen_h = 0;

    // directed: extremes, errors and every command
    cmd_q.push_back(mk(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_BDATA, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h1));
    cmd_q.push_back(mk(OP_DEFINE, 0, 0, 0, 0, 8191, 8191, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_DEFINE, 0, 0, 0, 0, 4096, 1, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_DEFINE, 0, 0, 0, 0, 8, 6, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 0, 0, 0, 0, 8, 0, 32760, 1, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 0, 5, 0, 0, 1, 0, 32766, 0, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 4095, 0, 0, 0, 2, 0, 0, 1, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 0, 0, 0, 0, 8, 0, 1020, 1, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 7, 1, 0, 0, 8, 0, 0, -1, 0, 0));
    cmd_q.push_back(mk(OP_MAPLN, 0, 2, 0, 0, 4, 0, 16, 1, 1, 0));
    cmd_q[$].strip = 1'b1;
    cmd_q.push_back(mk(OP_SET, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    cmd_q.push_back(mk(OP_GET, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_GET, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_GET, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_FILL, 0, 0, 0, 0, 8, 2, 0, 0, 0, 32'h00A5A5A5));
    cmd_q.push_back(mk(OP_SET, 2, 1, 0, 0, 0, 0, 0, 0, 0, 32'h0));
    cmd_q.push_back(mk(OP_COPY, 0, 0, 1, 0, 6, 2, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_KEYED, 0, 1, 0, 2, 8, 2, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_BSTART, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_BSTART, 1, 1, 0, 0, 2, 2, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++)
      cmd_q.push_back(mk(OP_BDATA, 0, 0, 0, 0, 0, 0, 0, 0, 0, (i == 1) ? 0 : 32'h10 + i));
    cmd_q.push_back(mk(4'hF, 4095, 4095, 4095, 4095, 4096, 4096, 32766, -128, 127, 0));
    for (int i = 0; i < N_RANDOM; i++) cmd_q.push_back(gen_cmd());
    n_total = cmd_q.size();
    n_sent = 0; n_results = 0; n_errors = 0; n_cycles = 0; phase = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all commands sent and every result back
    while (cmd_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d commands accepted, %0d result beats checked over four pacing phases",
             n_sent, n_results);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
